[sv/bmp24_stream_to_rgb565_pixels_unit_defines.svh]
//------------------------------------------------------------------------------
// BMP24 to RGB565 unit: assertion macros
// Shared concurrent-check shorthands; expect clk and rst_n in scope.
//------------------------------------------------------------------------------
`ifndef BMP24_STREAM_TO_RGB565_PIXELS_UNIT_DEFINES_SVH
`define BMP24_STREAM_TO_RGB565_PIXELS_UNIT_DEFINES_SVH

// same-cycle implication
`define BMP565_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMP565_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bmp565_pkg.sv]
//------------------------------------------------------------------------------
// BMP24 to RGB565 package
// Header offsets, codes and the structs passed between the unit's stages.
//------------------------------------------------------------------------------
package bmp565_pkg;

  localparam logic [15:0] MAX_DIMENSION = 16'd32767;

  localparam logic [31:0] HDR_LEN    = 32'd30;
  localparam logic [31:0] MIN_OFFSET = 32'd30;
  localparam logic [15:0] BPP_24     = 16'd24;
  localparam logic [7:0]  CHAR_B     = 8'h42;
  localparam logic [7:0]  CHAR_M     = 8'h4D;

  localparam logic [4:0] POS_SIG0 = 5'd0;
  localparam logic [4:0] POS_SIG1 = 5'd1;
  localparam logic [4:0] POS_OFS0 = 5'd10;
  localparam logic [4:0] POS_OFS1 = 5'd11;
  localparam logic [4:0] POS_OFS2 = 5'd12;
  localparam logic [4:0] POS_OFS3 = 5'd13;
  localparam logic [4:0] POS_W0   = 5'd18;
  localparam logic [4:0] POS_W1   = 5'd19;
  localparam logic [4:0] POS_W2   = 5'd20;
  localparam logic [4:0] POS_W3   = 5'd21;
  localparam logic [4:0] POS_H0   = 5'd22;
  localparam logic [4:0] POS_H1   = 5'd23;
  localparam logic [4:0] POS_H2   = 5'd24;
  localparam logic [4:0] POS_H3   = 5'd25;
  localparam logic [4:0] POS_BPP0 = 5'd28;
  localparam logic [4:0] POS_BPP1 = 5'd29;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_ROTATION = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  // pixel event from the parser, in file coordinates
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [15:0] col;
    logic [15:0] frow;
    logic [15:0] wm1;
    logic [15:0] hm1;
    logic [15:0] color;
  } pix_evt_t;

  // finished pixel in display coordinates
  typedef struct packed {
    logic        last;
    logic [15:0] color;
    logic [15:0] y;
    logic [15:0] x;
  } pix_t;

endpackage

[sv/bmp24_stream_to_rgb565_pixels_unit.sv]
//------------------------------------------------------------------------------
// BMP24 to RGB565 pixel unit
// Parses a 24-bit BMP byte stream and emits rotated, offset RGB565 pixels.
//------------------------------------------------------------------------------
// Takes one file byte per clock with no bubbles unless the output stalls; a
// byte passes an input register, then the parser and coordinate mapper, and
// its pixel lands in the output register when the red byte leaves the input register. One
// pixel per three data bytes; header, skipped and padding bytes give none.
// Mark the first byte of each file with in_tuser; after reset the first byte
// starts a file anyway. Change origin and rotation only between images.
module bmp24_stream_to_rgb565_pixels_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // file_byte
  input  logic        in_tuser,   // file_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pixel_x, pixel_y, pixel_color
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] origin_x_r;
  logic [15:0] origin_y_r;
  logic [1:0]  rotation_r;

  logic                 advance;
  logic                 word_valid;
  logic [7:0]           word_byte;
  logic                 word_start;
  logic                 fire;
  bmp565_pkg::pix_evt_t evt;
  bmp565_pkg::pix_t     pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      rotation_r <= bmp565_pkg::ROT_0;
    end else if (cfg_we) begin
      case (cfg_index)
        bmp565_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        bmp565_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        bmp565_pkg::CFG_ROTATION: rotation_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign fire = word_valid && advance;

  bmp565_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .word_valid (word_valid),
    .word_byte  (word_byte),
    .word_start (word_start)
  );

  bmp565_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .file_byte  (word_byte),
    .file_start (word_start),
    .evt        (evt)
  );

  bmp565_map u_map (
    .evt      (evt),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .rotation (rotation_r),
    .pix      (pix)
  );

  bmp565_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && evt.valid),
    .pix        (pix),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[sv/bmp565_in_stage.sv]
//------------------------------------------------------------------------------
// BMP24 to RGB565 input stage
// One-word input register; refills in the cycle it is consumed.
//------------------------------------------------------------------------------
module bmp565_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       advance,
  output logic       word_valid,
  output logic [7:0] word_byte,
  output logic       word_start
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       start_r;

  assign in_tready  = !valid_r || advance;
  assign word_valid = valid_r;
  assign word_byte  = byte_r;
  assign word_start = start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata;
      start_r <= in_tuser;
    end
  end

endmodule

[sv/bmp565_parse.sv]
//------------------------------------------------------------------------------
// BMP24 to RGB565 parser
// Header capture, offset skip, BGR assembly, row padding and row counting.
//------------------------------------------------------------------------------
`include "bmp24_stream_to_rgb565_pixels_unit_defines.svh"

module bmp565_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          file_byte,
  input  logic                file_start,
  output bmp565_pkg::pix_evt_t evt
);

  logic [31:0] byte_cnt_r, byte_cnt_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] bpp_r, bpp_nxt;
  logic        sig_ok_r, sig_ok_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] frow_r, frow_nxt;
  logic [16:0] rowb_r, rowb_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [10:0] part_r, part_nxt;
  logic        done_r, done_nxt;
  // geometry latched at the last header byte
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [15:0] wm1_r, wm1_nxt;
  logic [15:0] hm1_r, hm1_nxt;
  logic [16:0] rowpix_r, rowpix_nxt;
  logic [16:0] rowsz_r, rowsz_nxt;

  logic [31:0] pos;
  logic [16:0] rowb_inc;
  logic [15:0] frow_inc;
  logic        last;
  logic [16:0] rowpix_c;

  always_comb begin
    byte_cnt_nxt = file_start ? '0 : byte_cnt_r;
    offset_nxt   = file_start ? '0 : offset_r;
    width_nxt    = file_start ? '0 : width_r;
    height_nxt   = file_start ? '0 : height_r;
    bpp_nxt      = file_start ? '0 : bpp_r;
    sig_ok_nxt   = file_start ? 1'b0 : sig_ok_r;
    col_nxt      = file_start ? '0 : col_r;
    frow_nxt     = file_start ? '0 : frow_r;
    rowb_nxt     = file_start ? '0 : rowb_r;
    phase_nxt    = file_start ? bmp565_pkg::PH_BLUE : phase_r;
    part_nxt     = file_start ? '0 : part_r;
    done_nxt     = file_start ? 1'b0 : done_r;
    hdr_ok_nxt   = hdr_ok_r;
    wm1_nxt      = wm1_r;
    hm1_nxt      = hm1_r;
    rowpix_nxt   = rowpix_r;
    rowsz_nxt    = rowsz_r;
    rowpix_c     = 17'({1'b0, width_nxt}) + 17'({width_nxt, 1'b0});
    evt          = '0;
    evt.col      = col_r;
    evt.frow     = frow_r;
    evt.wm1      = wm1_r;
    evt.hm1      = hm1_r;
    evt.color    = {file_byte[7:3], part_r};
    last         = (col_r == wm1_r) && (frow_r == hm1_r);
    evt.last     = last;
    rowb_inc     = rowb_r + 17'd1;
    frow_inc     = frow_r + 16'd1;

    pos = byte_cnt_nxt;
    if (byte_cnt_nxt != '1) begin
      byte_cnt_nxt = byte_cnt_nxt + 32'd1;
    end

    if (pos < bmp565_pkg::HDR_LEN) begin
      case (pos[4:0])
        bmp565_pkg::POS_SIG0: sig_ok_nxt = (file_byte == bmp565_pkg::CHAR_B);
        bmp565_pkg::POS_SIG1: sig_ok_nxt = sig_ok_nxt && (file_byte == bmp565_pkg::CHAR_M);
        bmp565_pkg::POS_OFS0: offset_nxt[7:0]   = offset_nxt[7:0] | file_byte;
        bmp565_pkg::POS_OFS1: offset_nxt[15:8]  = offset_nxt[15:8] | file_byte;
        bmp565_pkg::POS_OFS2: offset_nxt[23:16] = offset_nxt[23:16] | file_byte;
        bmp565_pkg::POS_OFS3: offset_nxt[31:24] = offset_nxt[31:24] | file_byte;
        bmp565_pkg::POS_W0: width_nxt = {8'h00, file_byte};
        bmp565_pkg::POS_W1: width_nxt = width_nxt | {file_byte, 8'h00};
        bmp565_pkg::POS_W2, bmp565_pkg::POS_W3: begin
          if (file_byte != 8'h00) width_nxt = 16'hFFFF;
        end
        bmp565_pkg::POS_H0: height_nxt = {8'h00, file_byte};
        bmp565_pkg::POS_H1: height_nxt = height_nxt | {file_byte, 8'h00};
        bmp565_pkg::POS_H2, bmp565_pkg::POS_H3: begin
          if (file_byte != 8'h00) height_nxt = 16'hFFFF;
        end
        bmp565_pkg::POS_BPP0: bpp_nxt = {8'h00, file_byte};
        bmp565_pkg::POS_BPP1: begin
          bpp_nxt    = bpp_nxt | {file_byte, 8'h00};
          hdr_ok_nxt = sig_ok_nxt && (bpp_nxt == bmp565_pkg::BPP_24) &&
                       (width_nxt != '0) && (width_nxt <= bmp565_pkg::MAX_DIMENSION) &&
                       (height_nxt != '0) && (height_nxt <= bmp565_pkg::MAX_DIMENSION) &&
                       (offset_nxt >= bmp565_pkg::MIN_OFFSET);
          wm1_nxt    = width_nxt - 16'd1;
          hm1_nxt    = height_nxt - 16'd1;
          rowpix_nxt = rowpix_c;
          rowsz_nxt  = (rowpix_c + 17'd3) & ~17'd3;
        end
        default: ;
      endcase
    end else if (!done_r && hdr_ok_r && (pos >= offset_r)) begin
      if (rowb_r < rowpix_r) begin
        case (phase_r)
          bmp565_pkg::PH_BLUE: begin
            part_nxt  = {6'h00, file_byte[7:3]};
            phase_nxt = bmp565_pkg::PH_GREEN;
          end
          bmp565_pkg::PH_GREEN: begin
            part_nxt  = {file_byte[7:2], part_r[4:0]};
            phase_nxt = bmp565_pkg::PH_RED;
          end
          default: begin
            evt.valid = 1'b1;
            phase_nxt = bmp565_pkg::PH_BLUE;
            part_nxt  = '0;
            col_nxt   = col_r + 16'd1;
            if (last) done_nxt = 1'b1;
          end
        endcase
      end
      if (!(evt.valid && last)) begin
        rowb_nxt = rowb_inc;
        if (rowb_inc >= rowsz_r) begin
          rowb_nxt  = '0;
          col_nxt   = '0;
          phase_nxt = bmp565_pkg::PH_BLUE;
          part_nxt  = '0;
          frow_nxt  = frow_inc;
          if (frow_inc > hm1_r) done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      offset_r   <= '0;
      width_r    <= '0;
      height_r   <= '0;
      bpp_r      <= '0;
      sig_ok_r   <= 1'b0;
      col_r      <= '0;
      frow_r     <= '0;
      rowb_r     <= '0;
      phase_r    <= bmp565_pkg::PH_BLUE;
      part_r     <= '0;
      done_r     <= 1'b0;
      hdr_ok_r   <= 1'b0;
      wm1_r      <= '0;
      hm1_r      <= '0;
      rowpix_r   <= '0;
      rowsz_r    <= '0;
    end else if (fire) begin
      byte_cnt_r <= byte_cnt_nxt;
      offset_r   <= offset_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      bpp_r      <= bpp_nxt;
      sig_ok_r   <= sig_ok_nxt;
      col_r      <= col_nxt;
      frow_r     <= frow_nxt;
      rowb_r     <= rowb_nxt;
      phase_r    <= phase_nxt;
      part_r     <= part_nxt;
      done_r     <= done_nxt;
      hdr_ok_r   <= hdr_ok_nxt;
      wm1_r      <= wm1_nxt;
      hm1_r      <= hm1_nxt;
      rowpix_r   <= rowpix_nxt;
      rowsz_r    <= rowsz_nxt;
    end
  end

  `BMP565_ASSERT_NOW(a_evt_in_red, evt.valid, phase_r == bmp565_pkg::PH_RED, "pixel outside red phase")
  `BMP565_ASSERT_NOW(a_no_pix_done, evt.valid, !done_r && hdr_ok_r, "pixel after image end")
  `BMP565_ASSERT_NEXT(a_last_done, fire && evt.valid && evt.last, done_r, "image not closed")
  `BMP565_ASSERT_NOW(a_phase_ok, 1'b1, phase_r != 2'd3, "illegal pixel phase")

endmodule

[sv/bmp565_map.sv]
//------------------------------------------------------------------------------
// BMP24 to RGB565 coordinate mapper
// Bottom-up flip, rotation and origin offset, all modulo 2^16.
//------------------------------------------------------------------------------
module bmp565_map (
  input  bmp565_pkg::pix_evt_t evt,
  input  logic [15:0]          origin_x,
  input  logic [15:0]          origin_y,
  input  logic [1:0]           rotation,
  output bmp565_pkg::pix_t     pix
);

  logic [15:0] sy;
  logic [15:0] dx;
  logic [15:0] dy;

  always_comb begin
    sy = evt.hm1 - evt.frow;
    case (rotation)
      bmp565_pkg::ROT_90: begin
        dx = sy;
        dy = evt.wm1 - evt.col;
      end
      bmp565_pkg::ROT_180: begin
        dx = evt.wm1 - evt.col;
        dy = evt.frow;
      end
      bmp565_pkg::ROT_270: begin
        dx = evt.frow;
        dy = evt.col;
      end
      default: begin
        dx = evt.col;
        dy = sy;
      end
    endcase
    pix.x     = origin_x + dx;
    pix.y     = origin_y + dy;
    pix.color = evt.color;
    pix.last  = evt.last;
  end

endmodule

[sv/bmp565_out_stage.sv]
//------------------------------------------------------------------------------
// BMP24 to RGB565 output stage
// Result register; takes a new pixel in the cycle the old one is taken.
//------------------------------------------------------------------------------
module bmp565_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  bmp565_pkg::pix_t pix,
  output logic             advance,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tlast
);

  logic             valid_r;
  bmp565_pkg::pix_t pix_r;

  assign advance    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {pix_r.color, pix_r.y, pix_r.x};
  assign out_tlast  = pix_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load;
    end
    if (load) begin
      pix_r <= pix;
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// BMP24 to RGB565 pixel unit: testbench
// Streams BMP files into the unit one word per byte, mirrors the header parser,
// pixel assembly and coordinate mapping in a local decoder, and checks each
// pixel against the oldest prediction. Covers valid, broken, truncated and
// noisy files under several origin/rotation settings and handshake patterns.
//------------------------------------------------------------------------------
module testbench;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_WORDS = 110;

  typedef struct packed {
    logic       sof;
    logic [7:0] data;
  } file_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // file_byte
  logic        in_tuser = 1'b0;    // file_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;          // pixel_x, pixel_y, pixel_color
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = bmp565_pkg::CFG_ORIGIN_X;
  logic [15:0] cfg_data = 16'h0000;

  file_word_t         byte_stream[$];
  bmp565_pkg::pix_t   pixels_due[$];
  int unsigned words_queued = 0;
  int unsigned fails = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [7:0]  hdr[30];

  // decoder mirror
  logic [15:0] orig_x, orig_y;
  logic [1:0]  rot;
  logic [31:0] byte_pos, data_ofs;
  logic [15:0] img_w, img_h, depth, col, frow, partial;
  logic [16:0] row_bytes;
  logic [1:0]  phase;
  logic        sig_ok, img_done;

  bmp24_stream_to_rgb565_pixels_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_file();
    byte_pos = '0;
    data_ofs = '0;
    img_w = '0;
    img_h = '0;
    depth = '0;
    sig_ok = 1'b0;
    col = '0;
    frow = '0;
    row_bytes = '0;
    phase = bmp565_pkg::PH_BLUE;
    partial = '0;
    img_done = 1'b0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                     output bmp565_pkg::pix_t px);
    logic [31:0] pos;
    int unsigned w, h, row_span, sx, sy, dx, dy;
    bit fin;
    bit hit;
    px = '0;
    hit = 1'b0;
    if (sof) clear_file();
    pos = byte_pos;
    if (byte_pos != '1) byte_pos++;
    if (pos < bmp565_pkg::HDR_LEN) begin
      case (pos[4:0])
        bmp565_pkg::POS_SIG0: sig_ok = (b == bmp565_pkg::CHAR_B);
        bmp565_pkg::POS_SIG1: sig_ok = sig_ok && (b == bmp565_pkg::CHAR_M);
        bmp565_pkg::POS_OFS0, bmp565_pkg::POS_OFS1, bmp565_pkg::POS_OFS2,
        bmp565_pkg::POS_OFS3: data_ofs[8 * (pos - bmp565_pkg::POS_OFS0) +: 8] = b;
        bmp565_pkg::POS_W0: img_w = 16'(b);
        bmp565_pkg::POS_W1: img_w[15:8] = b;
        bmp565_pkg::POS_W2, bmp565_pkg::POS_W3: if (b != 8'h00) img_w = '1;
        bmp565_pkg::POS_H0: img_h = 16'(b);
        bmp565_pkg::POS_H1: img_h[15:8] = b;
        bmp565_pkg::POS_H2, bmp565_pkg::POS_H3: if (b != 8'h00) img_h = '1;
        bmp565_pkg::POS_BPP0: depth = 16'(b);
        bmp565_pkg::POS_BPP1: depth[15:8] = b;
        default: ;
      endcase
      return 1'b0;
    end
    if (img_done || !sig_ok || depth != bmp565_pkg::BPP_24 || img_w == 0 ||
        img_w > bmp565_pkg::MAX_DIMENSION || img_h == 0 ||
        img_h > bmp565_pkg::MAX_DIMENSION || data_ofs < bmp565_pkg::MIN_OFFSET ||
        pos < data_ofs)
      return 1'b0;

    w = img_w;
    h = img_h;
    row_span = ((w * 3 + 3) / 4) * 4;
    if (row_bytes < w * 3) begin
      case (phase)
        bmp565_pkg::PH_BLUE: begin
          partial = 16'(b >> 3);
          phase = bmp565_pkg::PH_GREEN;
        end
        bmp565_pkg::PH_GREEN: begin
          partial = partial | (16'(b & 8'hFC) << 3);
          phase = bmp565_pkg::PH_RED;
        end
        default: begin
          sx = col;
          sy = h - 1 - frow;
          fin = (col == w - 1) && (frow == h - 1);
          case (rot)
            bmp565_pkg::ROT_90: begin dx = sy; dy = w - 1 - sx; end
            bmp565_pkg::ROT_180: begin dx = w - 1 - sx; dy = h - 1 - sy; end
            bmp565_pkg::ROT_270: begin dx = h - 1 - sy; dy = sx; end
            default: begin dx = sx; dy = sy; end
          endcase
          px.x = 16'(orig_x + dx);
          px.y = 16'(orig_y + dy);
          px.color = partial | (16'(b & 8'hF8) << 8);
          px.last = fin;
          hit = 1'b1;
          phase = bmp565_pkg::PH_BLUE;
          partial = '0;
          col++;
          if (fin) begin
            img_done = 1'b1;
            return 1'b1;
          end
        end
      endcase
    end
    row_bytes++;
    if (row_bytes >= row_span) begin
      row_bytes = '0;
      col = '0;
      phase = bmp565_pkg::PH_BLUE;
      partial = '0;
      frow++;
      if (frow >= h) img_done = 1'b1;
    end
    return hit;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, seen);
      fails++;
    end
  endfunction

  // driver
  always @(posedge clk) begin : drive
    file_word_t w;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = byte_stream.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= w.data;
          in_tuser <= w.sof;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin : observe
    bmp565_pkg::pix_t due, got;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        if (decode_byte(in_tdata, in_tuser, due)) pixels_due.push_back(due);
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = {out_tlast, out_tdata};
        if (pixels_due.size() == 0) begin
          $error("pixel with none expected: x 0x%h y 0x%h colour 0x%h",
                 got.x, got.y, got.color);
          fails++;
        end else begin
          due = pixels_due.pop_front();
          check_field("pixel_x", due.x, got.x);
          check_field("pixel_y", due.y, got.y);
          check_field("pixel_color", due.color, got.color);
          check_field("last_pixel", 16'(due.last), 16'(got.last));
        end
      end
    end
    if (moved || (byte_stream.size() == 0 && !in_tvalid && pixels_due.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_word(input logic sof, input logic [7:0] b);
    byte_stream.push_back('{sof: sof, data: b});
    words_queued++;
  endtask

  task automatic fill_header(input logic [31:0] ofs, input logic [31:0] w32,
                             input logic [31:0] h32, input logic [15:0] bpp);
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[bmp565_pkg::POS_SIG0] = bmp565_pkg::CHAR_B;
    hdr[bmp565_pkg::POS_SIG1] = bmp565_pkg::CHAR_M;
    for (int i = 0; i < 4; i++) begin
      hdr[bmp565_pkg::POS_OFS0 + i] = ofs[8 * i +: 8];
      hdr[bmp565_pkg::POS_W0 + i] = w32[8 * i +: 8];
      hdr[bmp565_pkg::POS_H0 + i] = h32[8 * i +: 8];
    end
    hdr[bmp565_pkg::POS_BPP0] = bpp[7:0];
    hdr[bmp565_pkg::POS_BPP1] = bpp[15:8];
  endtask

  // header, then n_after random bytes (gap, pixel data, trailing)
  task automatic send_file(input bit mark, input int unsigned n_after);
    for (int i = 0; i < 30; i++) push_word(mark && i == 0, hdr[i]);
    repeat (n_after) push_word(1'b0, 8'($urandom));
  endtask

  task automatic random_file();
    int unsigned kind, w, h, ofs, body, trail;
    kind = $urandom_range(99);
    if (kind < 5) begin
      repeat ($urandom_range(60, 1)) push_word($urandom_range(7) == 0, 8'($urandom));
      return;
    end
    w = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(5, 1);
    h = $urandom_range(5, 1);
    ofs = ($urandom_range(2) == 0) ? $urandom_range(45, 31) : 30;
    body = ((w * 3 + 3) / 4) * 4 * h;
    trail = ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0;
    fill_header(ofs, w, h, bmp565_pkg::BPP_24);
    if (kind < 20) begin
      case ($urandom_range(6))
        0: hdr[bmp565_pkg::POS_SIG0] = 8'($urandom);
        1: hdr[bmp565_pkg::POS_SIG1] = 8'($urandom);
        2: begin
          hdr[bmp565_pkg::POS_BPP0] = 8'($urandom);
          hdr[bmp565_pkg::POS_BPP1] = 8'($urandom_range(1));
        end
        3: hdr[bmp565_pkg::POS_W2 + $urandom_range(1)] = 8'($urandom_range(255, 1));
        4: hdr[bmp565_pkg::POS_H2 + $urandom_range(1)] = 8'($urandom_range(255, 1));
        5: begin
          hdr[bmp565_pkg::POS_OFS0] = 8'($urandom_range(29));
          hdr[bmp565_pkg::POS_OFS1] = 8'h00;
          hdr[bmp565_pkg::POS_OFS2] = 8'h00;
          hdr[bmp565_pkg::POS_OFS3] = 8'h00;
        end
        default: begin
          if ($urandom_range(1)) begin
            hdr[bmp565_pkg::POS_W0] = 8'h00;
            hdr[bmp565_pkg::POS_W1] = 8'h00;
          end else begin
            hdr[bmp565_pkg::POS_H1] = hdr[bmp565_pkg::POS_H1] | 8'h80;
          end
        end
      endcase
    end else if (kind < 30) begin
      body = $urandom_range(body);
    end
    send_file($urandom_range(19) != 0, ofs - 30 + body + trail);
  endtask

  task automatic drain();
    while (byte_stream.size() != 0 || in_tvalid || pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] r);
    cfg_we <= 1'b1;
    cfg_index <= bmp565_pkg::CFG_ORIGIN_X;
    cfg_data <= x;
    @(posedge clk);
    cfg_index <= bmp565_pkg::CFG_ORIGIN_Y;
    cfg_data <= y;
    @(posedge clk);
    cfg_index <= bmp565_pkg::CFG_ROTATION;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    orig_x = x;
    orig_y = y;
    rot = r[1:0];
  endtask

  initial begin
    logic [15:0] ox, oy;
    orig_x = '0;
    orig_y = '0;
    rot = bmp565_pkg::ROT_0;
    clear_file();

    // first file carries no start mark
    fill_header(30, 2, 2, bmp565_pkg::BPP_24);
    send_file(1'b0, 16 + 3);
    fill_header(34, 3, 1, bmp565_pkg::BPP_24);
    send_file(1'b1, 4 + 12);
    fill_header(30, 4, 2, bmp565_pkg::BPP_24);
    send_file(1'b1, 24);
    fill_header(30, 1, 1, bmp565_pkg::BPP_24);
    hdr[bmp565_pkg::POS_SIG0] = bmp565_pkg::CHAR_M;
    send_file(1'b1, 4);
    fill_header(30, 1, 1, bmp565_pkg::BPP_24);
    hdr[bmp565_pkg::POS_SIG1] = bmp565_pkg::CHAR_B;
    send_file(1'b1, 4);
    fill_header(30, 1, 1, 16'd32);
    send_file(1'b1, 4);
    fill_header(30, 1, 1, 16'h0118);
    send_file(1'b1, 4);
    fill_header(30, 0, 1, bmp565_pkg::BPP_24);
    send_file(1'b1, 4);
    fill_header(30, 1, 0, bmp565_pkg::BPP_24);
    send_file(1'b1, 4);
    fill_header(30, 32'h0001_0001, 1, bmp565_pkg::BPP_24);
    send_file(1'b1, 4);
    fill_header(30, 1, 32'h0100_0001, bmp565_pkg::BPP_24);
    send_file(1'b1, 4);
    fill_header(30, 32768, 1, bmp565_pkg::BPP_24);
    send_file(1'b1, 4);
    fill_header(29, 1, 1, bmp565_pkg::BPP_24);
    send_file(1'b1, 5);
    fill_header(30, bmp565_pkg::MAX_DIMENSION, 1, bmp565_pkg::BPP_24);
    send_file(1'b1, 9);
    fill_header(30, 1, bmp565_pkg::MAX_DIMENSION, bmp565_pkg::BPP_24);
    send_file(1'b1, 20);
    fill_header(31, 3, 3, bmp565_pkg::BPP_24);
    send_file(1'b1, 1 + 14);
    fill_header(30, 1, 1, bmp565_pkg::BPP_24);
    send_file(1'b1, 4 + 5);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph >> 1)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (ph)
        0: begin ox = 16'h0000; oy = 16'h0000; end
        1: begin ox = 16'hFFFF; oy = 16'hFFFF; end
        2: begin ox = 16'hFFFF; oy = 16'h0000; end
        3: begin ox = 16'h0000; oy = 16'hFFFE; end
        default: begin ox = 16'($urandom); oy = 16'($urandom); end
      endcase
      write_regs(ox, oy, {14'($urandom), 2'(ph)});
      begin
        int unsigned quota;
        quota = words_queued + PHASE_WORDS;
        while (words_queued < quota) random_file();
      end
      drain();
    end

    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/bmp565_pkg.sv
sv/bmp565_in_stage.sv
sv/bmp565_parse.sv
sv/bmp565_map.sv
sv/bmp565_out_stage.sv
sv/bmp24_stream_to_rgb565_pixels_unit.sv
dv/testbench.sv
